/* rtl/core/field_map_linear_interpolator_assert.svh */
// assertion macros for the field map interpolator checker
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef FIELD_MAP_LINEAR_INTERPOLATOR_ASSERT_SVH
`define FIELD_MAP_LINEAR_INTERPOLATOR_ASSERT_SVH

// condition implies consequence in the same cycle
`define FLI_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define FLI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/fli_pkg.sv */
// shared types and constants of the field map interpolator
// no dependencies
package fli_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int TABLE_AW    = $clog2(TABLE_DEPTH);

    localparam int POS_W   = 24;
    localparam int FIELD_W = 32;
    localparam int CNT_W   = 11;
    localparam int CFG_AW  = 2;
    localparam int CFG_DW  = 24;

    // shared multiply / divide unit widths
    localparam int MCAND_W   = FIELD_W + 1;          // |f1 - f0|
    localparam int MPLIER_W  = POS_W + 1;            // |q - p0|, |p1 - p0|
    localparam int ACC_W     = MCAND_W + MPLIER_W - 1;
    localparam int MUL_STEPS = MPLIER_W;
    localparam int DIV_STEPS = ACC_W;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_WINDOW = 2'd1,
        ST_NOSEG  = 2'd2,
        ST_ZERO   = 2'd3
    } t_status;

    typedef enum logic [CFG_AW-1:0] {
        REG_WINDOW_LOW     = 2'd0,
        REG_WINDOW_HIGH    = 2'd1,
        REG_ENTRIES_IN_USE = 2'd2
    } t_reg_idx;

    typedef struct packed {
        t_op                        operation;
        logic [9:0]                 entry_index;
        logic signed [POS_W-1:0]    position;
        logic signed [FIELD_W-1:0]  field_value;
    } t_fli_in;

    typedef struct packed {
        logic signed [FIELD_W-1:0]  field_z;
        t_status                    status;
    } t_fli_out;

    typedef struct packed {
        logic signed [POS_W-1:0]    position;
        logic signed [FIELD_W-1:0]  field_value;
    } t_fli_entry;

    typedef struct packed {
        logic                  mul_go;
        logic                  div_go;
        logic [MCAND_W-1:0]    mcand;
        logic [MPLIER_W-1:0]   mplier;
        logic [MPLIER_W-1:0]   divisor;
    } t_alu_req;

    typedef struct packed {
        logic                  done;
        logic [ACC_W-1:0]      acc;
    } t_alu_rsp;

endpackage

/* rtl/core/fli_table.sv */
// field map table: position and field value per entry
// one write port, one read port with registered data; uses fli_pkg
module fli_table
    import fli_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [TABLE_AW-1:0]  i_waddr,
    input  t_fli_entry           i_wdata,
    input  logic [TABLE_AW-1:0]  i_raddr,
    output t_fli_entry           o_rdata
);

    t_fli_entry r_mem [TABLE_DEPTH];
    t_fli_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/fli_alu.sv */
// shared shift-add multiplier and restoring divider on magnitudes
// product stays in the accumulator and becomes the dividend; uses fli_pkg
module fli_alu
    import fli_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_alu_req  i_req,
    output t_alu_rsp  o_rsp
);

    typedef enum logic [1:0] {
        A_IDLE,
        A_MUL,
        A_DIV
    } t_mode;

    t_mode                r_mode;
    logic                 r_done;
    logic [STEP_W-1:0]    r_cnt;
    logic [ACC_W-1:0]     r_acc;
    logic [MCAND_W-1:0]   r_mcand;
    logic [MPLIER_W-1:0]  r_mplier;
    logic [MPLIER_W-1:0]  r_div;
    logic [MPLIER_W-1:0]  r_rem;

    logic [ACC_W-1:0]     mul_next;
    logic [MPLIER_W:0]    trial;
    logic [MPLIER_W+1:0]  diff;
    logic                 fit;

    always_comb begin
        mul_next = {r_acc[ACC_W-2:0], 1'b0}
                 + (r_mplier[MPLIER_W-1] ? ACC_W'(r_mcand) : '0);
        trial    = {r_rem, r_acc[ACC_W-1]};
        diff     = {1'b0, trial} - {2'b00, r_div};
        fit      = ~diff[MPLIER_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= A_IDLE;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_mode)
                A_IDLE: begin
                    r_cnt <= '0;
                    if (i_req.mul_go) begin
                        r_acc    <= '0;
                        r_mcand  <= i_req.mcand;
                        r_mplier <= i_req.mplier;
                        r_mode   <= A_MUL;
                    end else if (i_req.div_go) begin
                        r_rem  <= '0;
                        r_div  <= i_req.divisor;
                        r_mode <= A_DIV;
                    end
                end
                A_MUL: begin
                    r_acc    <= mul_next;
                    r_mplier <= {r_mplier[MPLIER_W-2:0], 1'b0};
                    r_cnt    <= r_cnt + 1'b1;
                    if (r_cnt == STEP_W'(MUL_STEPS - 1)) begin
                        r_mode <= A_IDLE;
                        r_done <= 1'b1;
                    end
                end
                A_DIV: begin
                    r_acc <= {r_acc[ACC_W-2:0], fit};
                    r_rem <= fit ? diff[MPLIER_W-1:0] : trial[MPLIER_W-1:0];
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == STEP_W'(DIV_STEPS - 1)) begin
                        r_mode <= A_IDLE;
                        r_done <= 1'b1;
                    end
                end
                default: begin
                    r_mode <= A_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.acc  = r_acc;

endmodule

/* rtl/core/field_map_linear_interpolator.sv */
// field map linear interpolator: a write goes straight into the table, ready stays high
// a query outside the window or with fewer than two entries goes straight to the emit
// state; else the walk reads one entry per cycle up to the first entry above the query
// (no segment if none), then a zero-width segment is flagged, or 25 multiply and 57
// divide steps run in the shared unit
// one query at a time; sync active-low reset clears control, loads register resets
module field_map_linear_interpolator
    import fli_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_fli_in            i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_fli_out           o_out,
    input  logic               i_cfg_we,
    input  logic [CFG_AW-1:0]  i_cfg_index,
    input  logic [CFG_DW-1:0]  i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_SETUP,
        S_CHECK,
        S_MUL,
        S_DIV,
        S_SIGN,
        S_SUM,
        S_EMIT
    } t_state;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic signed [POS_W-1:0]  r_win_lo;
    logic signed [POS_W-1:0]  r_win_hi;
    logic [CNT_W-1:0]         r_entries;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_lo  <= -24'sd500000;
            r_win_hi  <= 24'sd500000;
            r_entries <= 11'd1001;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WINDOW_LOW:     r_win_lo  <= i_cfg_data;
                REG_WINDOW_HIGH:    r_win_hi  <= i_cfg_data;
                REG_ENTRIES_IN_USE: r_entries <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // sequencer registers
    // ---------------------------------------------------------------
    t_state                     r_state, n_state;
    logic signed [POS_W-1:0]    r_q, n_q;              // query position
    logic [TABLE_AW-1:0]        r_addr, n_addr;        // table read address
    logic [TABLE_AW-1:0]        r_didx, n_didx;        // entry shown on read data
    logic                       r_dv, n_dv;            // read data is meaningful
    logic [TABLE_AW-1:0]        r_last, n_last;        // last entry searched
    t_fli_entry                 r_prev, n_prev;        // entry at the segment start
    t_fli_entry                 r_cur, n_cur;          // first entry above query
    logic signed [POS_W:0]      r_dz, n_dz;            // segment width
    logic signed [POS_W:0]      r_dq, n_dq;            // query minus segment start
    logic signed [FIELD_W:0]    r_df, n_df;            // field step across segment
    logic                       r_neg, n_neg;          // sign of the quotient
    logic [MPLIER_W-1:0]        r_dz_mag, n_dz_mag;
    logic signed [ACC_W:0]      r_qs, n_qs;            // signed quotient
    logic signed [FIELD_W-1:0]  r_fz, n_fz;
    t_status                    r_st, n_st;
    logic                       r_out_valid, n_out_valid;
    t_fli_out                   r_out, n_out;

    // ---------------------------------------------------------------
    // table and shared arithmetic unit
    // ---------------------------------------------------------------
    logic        in_fire;
    logic        tbl_we;
    t_fli_entry  tbl_wdata;
    t_fli_entry  rd;
    t_alu_req    alu_req;
    t_alu_rsp    alu_rsp;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;

    // writes land straight in the table, entries past the depth are dropped
    assign tbl_we = in_fire && (i_in.operation == OP_WRITE)
                 && (32'(i_in.entry_index) < TABLE_DEPTH);
    assign tbl_wdata.position    = i_in.position;
    assign tbl_wdata.field_value = i_in.field_value;

    fli_table u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (TABLE_AW'(i_in.entry_index)),
        .i_wdata (tbl_wdata),
        .i_raddr (r_addr),
        .o_rdata (rd)
    );

    fli_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    // ---------------------------------------------------------------
    // next-state logic
    // ---------------------------------------------------------------
    logic                    in_win;
    logic [CNT_W-1:0]        n_eff;     // entry count clamped to the table
    logic signed [ACC_W+1:0] sum;

    always_comb begin
        in_win = (i_in.position >= r_win_lo) && (i_in.position <= r_win_hi);
        n_eff  = (32'(r_entries) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : r_entries;
        sum    = {r_qs[ACC_W], r_qs}
               + {{(ACC_W + 2 - FIELD_W){r_prev.field_value[FIELD_W-1]}},
                  r_prev.field_value};

        n_state  = r_state;
        n_q      = r_q;
        n_addr   = r_addr;
        n_didx   = r_didx;
        n_dv     = r_dv;
        n_last   = r_last;
        n_prev   = r_prev;
        n_cur    = r_cur;
        n_dz     = r_dz;
        n_dq     = r_dq;
        n_df     = r_df;
        n_neg    = r_neg;
        n_dz_mag = r_dz_mag;
        n_qs     = r_qs;
        n_fz     = r_fz;
        n_st     = r_st;
        n_out    = r_out;

        alu_req.mul_go  = 1'b0;
        alu_req.div_go  = 1'b0;
        alu_req.mcand   = r_df[FIELD_W] ? MCAND_W'(-r_df) : MCAND_W'(r_df);
        alu_req.mplier  = r_dq[POS_W] ? MPLIER_W'(-r_dq) : MPLIER_W'(r_dq);
        alu_req.divisor = r_dz_mag;

        // output slot frees when its item is taken
        n_out_valid = r_out_valid && !i_out_ready;

        case (r_state)
            S_IDLE: begin
                if (in_fire && (i_in.operation == OP_QUERY)) begin
                    n_q  = i_in.position;
                    n_fz = '0;
                    if (!in_win) begin
                        n_st    = ST_WINDOW;
                        n_state = S_EMIT;
                    end else if (n_eff < CNT_W'(2)) begin
                        n_st    = ST_NOSEG;
                        n_state = S_EMIT;
                    end else begin
                        n_addr  = '0;
                        n_dv    = 1'b0;
                        n_last  = TABLE_AW'(n_eff - 1'b1);
                        n_state = S_SEARCH;
                    end
                end
            end
            // one read issued per cycle, data for the previous address compared
            S_SEARCH: begin
                n_addr = r_addr + 1'b1;
                n_didx = r_addr;
                n_dv   = 1'b1;
                if (r_dv) begin
                    if (r_didx == '0) begin
                        n_prev = rd;
                    end else if (rd.position > r_q) begin
                        n_cur   = rd;
                        n_state = S_SETUP;
                    end else begin
                        n_prev = rd;
                        if (r_didx == r_last) begin
                            n_st    = ST_NOSEG;
                            n_state = S_EMIT;
                        end
                    end
                end
            end
            S_SETUP: begin
                n_dz = {r_cur.position[POS_W-1], r_cur.position}
                     - {r_prev.position[POS_W-1], r_prev.position};
                n_dq = {r_q[POS_W-1], r_q}
                     - {r_prev.position[POS_W-1], r_prev.position};
                n_df = {r_cur.field_value[FIELD_W-1], r_cur.field_value}
                     - {r_prev.field_value[FIELD_W-1], r_prev.field_value};
                n_state = S_CHECK;
            end
            // zero-width segment gives no division
            S_CHECK: begin
                if (r_dz == '0) begin
                    n_st    = ST_ZERO;
                    n_state = S_EMIT;
                end else begin
                    alu_req.mul_go = 1'b1;
                    n_neg    = r_df[FIELD_W] ^ r_dq[POS_W] ^ r_dz[POS_W];
                    n_dz_mag = r_dz[POS_W] ? MPLIER_W'(-r_dz) : MPLIER_W'(r_dz);
                    n_state  = S_MUL;
                end
            end
            S_MUL: begin
                if (alu_rsp.done) begin
                    alu_req.div_go = 1'b1;
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                if (alu_rsp.done) begin
                    n_state = S_SIGN;
                end
            end
            // magnitude quotient truncates toward zero, sign applied after
            S_SIGN: begin
                n_qs    = r_neg ? -$signed({1'b0, alu_rsp.acc})
                                :  $signed({1'b0, alu_rsp.acc});
                n_state = S_SUM;
            end
            S_SUM: begin
                if (sum > $signed((ACC_W + 2)'(32'sh7FFFFFFF))) begin
                    n_fz = 32'sh7FFFFFFF;
                end else if (sum < -$signed((ACC_W + 2)'(33'sh080000000))) begin
                    n_fz = 32'sh80000000;
                end else begin
                    n_fz = sum[FIELD_W-1:0];
                end
                n_st    = ST_OK;
                n_state = S_EMIT;
            end
            // hold the result until the output register is free
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.field_z = r_fz;
                    n_out.status  = r_st;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_dv        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_dv        <= n_dv;
        end
        r_q      <= n_q;
        r_addr   <= n_addr;
        r_didx   <= n_didx;
        r_last   <= n_last;
        r_prev   <= n_prev;
        r_cur    <= n_cur;
        r_dz     <= n_dz;
        r_dq     <= n_dq;
        r_df     <= n_df;
        r_neg    <= n_neg;
        r_dz_mag <= n_dz_mag;
        r_qs     <= n_qs;
        r_fz     <= n_fz;
        r_st     <= n_st;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* rtl/core/fli_checker.sv */
// port-level checks for the field map interpolator, bound to the top level
// uses fli_pkg and field_map_linear_interpolator_assert.svh
`include "field_map_linear_interpolator_assert.svh"

module fli_checker
    import fli_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_fli_in   i_in,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_fli_out  o_out
);

    // any result that is not interpolated carries a zero field
    `FLI_ASSERT_SAME(a_zero_unless_ok, o_out_valid && (o_out.status != ST_OK), o_out.field_z == '0, "nonzero field with error status")

    // a stalled result holds
    `FLI_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out), "result changed while stalled")

    // a query leaves the block busy in the next cycle
    `FLI_ASSERT_NEXT(a_query_busy, i_in_valid && o_in_ready && (i_in.operation == OP_QUERY), !o_in_ready, "ready right after a query")

    // a table write never blocks the next item
    `FLI_ASSERT_NEXT(a_write_ready, i_in_valid && o_in_ready && (i_in.operation == OP_WRITE), o_in_ready, "not ready after a write")

endmodule

bind field_map_linear_interpolator fli_checker u_fli_checker (.*);

/* tb/tb_top.sv */
// tb_top: self-checking testbench for the field map linear interpolator
// needs fli_pkg and the field_map_linear_interpolator top level only
// loads the map, queries it under many register settings and checks every result
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import fli_pkg::*;

    // run shape
    localparam int HOLD_OFF_CYCLES = 2500;   // long receiver hold-off to back up the block
    localparam int IDLE_LIMIT      = 20000;  // watchdog: cycles with no item moving at all
    localparam int SETTLE_CYCLES   = 8;      // a write gives no result, let it retire
    localparam int TAIL_CYCLES     = 1200;   // longest query is a full walk plus divide
    localparam int RANDOM_ITEMS    = 540;

    localparam logic signed [POS_W-1:0]   POS_MIN   = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic signed [POS_W-1:0]   POS_MAX   = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [FIELD_W-1:0] FIELD_MIN = {1'b1, {(FIELD_W-1){1'b0}}};
    localparam logic signed [FIELD_W-1:0] FIELD_MAX = {1'b0, {(FIELD_W-1){1'b1}}};

    // receiver stall patterns, picked at random by the receiver itself
    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PERIODIC,
        RX_COIN
    } t_rx_mode;

    // ------------------------------------------------------------------
    // clock, reset and the signals around the block
    // ------------------------------------------------------------------
    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    t_fli_in             in_item   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    t_fli_out            out_item;
    logic                cfg_we    = 1'b0;
    logic [CFG_AW-1:0]   cfg_index = '0;
    logic [CFG_DW-1:0]   cfg_data  = '0;

    always #5 clk = ~clk;

    field_map_linear_interpolator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // predictor state: our own copy of the map and the registers
    // ------------------------------------------------------------------
    logic signed [POS_W-1:0]   map_pos   [TABLE_DEPTH];
    logic signed [FIELD_W-1:0] map_field [TABLE_DEPTH];
    logic signed [POS_W-1:0]   win_lo    = POS_W'(-500000);
    logic signed [POS_W-1:0]   win_hi    = POS_W'(500000);
    logic [CNT_W-1:0]          n_entries = CNT_W'(1001);

    // expected query results, oldest first
    t_fli_out field_expected [$];

    int fail_count   = 0;
    int n_writes     = 0;
    int n_queries    = 0;
    int n_settings   = 0;
    int status_count [4];

    // sender burst state; gap_max of zero means no idling on the input side
    int burst_left = 0;
    int gap_max    = 6;

    // receiver state; hold_request is how a test asks for a long hold-off
    int       hold_request = 0;
    int       hold_left    = 0;
    int       rx_cycle     = 0;
    t_rx_mode stall_mode   = RX_ALWAYS;

    int idle_cycles = 0;

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------
    function automatic logic signed [POS_W-1:0] clamp_pos(input longint v);
        if (v > POS_MAX) return POS_MAX;
        if (v < POS_MIN) return POS_MIN;
        return v[POS_W-1:0];
    endfunction

    function automatic t_fli_in make_write(input logic [9:0] idx,
                                           input logic signed [POS_W-1:0] pos,
                                           input logic signed [FIELD_W-1:0] fv);
        t_fli_in it;
        it.operation   = OP_WRITE;
        it.entry_index = idx;
        it.position    = pos;
        it.field_value = fv;
        return it;
    endfunction

    // index and field value are don't-care on a query, so keep them moving
    function automatic t_fli_in make_query(input logic signed [POS_W-1:0] pos);
        t_fli_in it;
        it.operation   = OP_QUERY;
        it.entry_index = 10'($urandom());
        it.position    = pos;
        it.field_value = $urandom();
        return it;
    endfunction

    // expected field at a query position, from the current map and registers
    function automatic t_fli_out predict_field(input logic signed [POS_W-1:0] q);
        t_fli_out    r;
        int unsigned lim;
        longint      p0, dz, f0, df, acc;
        r.field_z = '0;
        r.status  = ST_NOSEG;
        if (q < win_lo || q > win_hi) begin
            r.status = ST_WINDOW;
            return r;
        end
        // counts past the table depth just search the whole table
        lim = (n_entries > TABLE_DEPTH) ? TABLE_DEPTH : n_entries;
        for (int i = 1; i < lim; i++) begin
            if (map_pos[i] > q) begin
                p0 = map_pos[i-1];
                dz = longint'(map_pos[i]) - p0;
                f0 = map_field[i-1];
                df = longint'(map_field[i]) - f0;
                if (dz == 0) begin
                    r.status = ST_ZERO;
                    return r;
                end
                // exact 64-bit product, division truncates toward zero
                acc = (df * (longint'(q) - p0)) / dz + f0;
                if (acc > FIELD_MAX)
                    r.field_z = FIELD_MAX;
                else if (acc < FIELD_MIN)
                    r.field_z = FIELD_MIN;
                else
                    r.field_z = acc[FIELD_W-1:0];
                r.status = ST_OK;
                return r;
            end
        end
        return r;
    endfunction

    // offer one item; returns right after the edge that accepted it
    task automatic send_item(input t_fli_in item);
        int       gap;
        t_fli_out want;
        if (burst_left == 0) begin
            gap = (gap_max == 0 || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, gap_max);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge clk); while (!in_ready);
        // item taken: update the map or queue what the query must return
        if (item.operation == OP_WRITE) begin
            map_pos[item.entry_index]   = item.position;
            map_field[item.entry_index] = item.field_value;
            n_writes++;
        end else begin
            want = predict_field(item.position);
            field_expected.push_back(want);
            status_count[want.status]++;
            n_queries++;
        end
    endtask

    // stop offering until every query has answered, then let trailing writes retire
    task automatic drain_results();
        in_valid  <= 1'b0;
        burst_left = 0;
        while (field_expected.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DW-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_WINDOW_LOW:     win_lo = value[POS_W-1:0];
            REG_WINDOW_HIGH:    win_hi = value[POS_W-1:0];
            REG_ENTRIES_IN_USE: n_entries = value[CNT_W-1:0];
            default: ;
        endcase
    endtask

    // registers only change with the block idle
    task automatic apply_settings(input logic signed [POS_W-1:0] lo,
                                  input logic signed [POS_W-1:0] hi,
                                  input logic [CNT_W-1:0] count);
        drain_results();
        write_reg(REG_WINDOW_LOW, lo);
        write_reg(REG_WINDOW_HIGH, hi);
        write_reg(REG_ENTRIES_IN_USE, CFG_DW'(count));
        n_settings++;
    endtask

    // entries 0..count-1 with rising positions; a zero step now and then
    // leaves a zero-width segment, clamping at the top does the same
    task automatic load_ramp(input int count, input longint start, input int max_step,
                             input bit full_fields, output longint lo_pos,
                             output longint hi_pos);
        longint                    p;
        logic signed [FIELD_W-1:0] fv;
        p      = start;
        lo_pos = clamp_pos(start);
        hi_pos = lo_pos;
        for (int k = 0; k < count; k++) begin
            fv = full_fields ? $urandom() : $urandom_range(0, 2000000) - 1000000;
            send_item(make_write(10'(k), clamp_pos(p), fv));
            hi_pos = clamp_pos(p);
            p += ($urandom_range(0, 7) == 0) ? 0 : longint'($urandom_range(1, max_step));
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // whole table first, so no query ever reads an entry that was never written;
    // then queries against the reset register values (window +-500000, 1001 entries)
    task automatic test_table_load();
        longint lo_pos, hi_pos;
        load_ramp(TABLE_DEPTH, -511000, 1000, 1'b1, lo_pos, hi_pos);
        send_item(make_query(clamp_pos(-500001)));
        send_item(make_query(clamp_pos(-500000)));
        send_item(make_query(map_pos[500]));
        send_item(make_query(clamp_pos(500000)));    // walks all 1000 segments
        send_item(make_query(clamp_pos(500001)));
    endtask

    // extreme positions and field values, both index extremes, both operations
    task automatic test_field_extremes();
        apply_settings(POS_MIN, POS_MAX, CNT_W'(4));
        send_item(make_write(10'd0, POS_MIN, FIELD_MIN));
        send_item(make_write(10'd1, '0, FIELD_MAX));
        send_item(make_write(10'd2, POS_MAX, FIELD_MIN));
        send_item(make_write(10'd3, POS_MAX, '0));
        send_item(make_write(10'd1023, POS_MAX, '1));
        send_item(make_query(POS_MIN));              // exactly on entry 0
        send_item(make_query(clamp_pos(-1)));
        send_item(make_query(clamp_pos(8388606)));   // full-range field swing
        send_item(make_query(POS_MAX));              // no entry above the query
    endtask

    task automatic test_special_cases();
        apply_settings(POS_MIN, POS_MAX, CNT_W'(2));
        // zero-width segment: entry 1 found but sits on entry 0
        send_item(make_write(10'd0, clamp_pos(100), 32'sd5));
        send_item(make_write(10'd1, clamp_pos(100), 32'sd9));
        send_item(make_query(clamp_pos(50)));
        // negative width: entry 0 above entry 1
        send_item(make_write(10'd0, clamp_pos(300), 32'sd1000));
        send_item(make_write(10'd1, clamp_pos(200), -32'sd1000));
        send_item(make_query(clamp_pos(150)));
        // extrapolation far below entry 0 saturates low, then high
        send_item(make_write(10'd0, '0, '0));
        send_item(make_write(10'd1, clamp_pos(1), FIELD_MAX));
        send_item(make_query(clamp_pos(-1000)));
        send_item(make_write(10'd1, clamp_pos(1), FIELD_MIN));
        send_item(make_query(clamp_pos(-1000)));
    endtask

    // inverted window, single-point window, entry counts below two
    task automatic test_register_corners();
        apply_settings(clamp_pos(100), clamp_pos(-100), CNT_W'(2));
        send_item(make_query('0));
        apply_settings(clamp_pos(7), clamp_pos(7), CNT_W'(2));
        send_item(make_query(clamp_pos(6)));
        send_item(make_query(clamp_pos(7)));
        send_item(make_query(clamp_pos(8)));
        apply_settings(POS_MIN, POS_MAX, CNT_W'(0));
        send_item(make_query('0));
        apply_settings(POS_MIN, POS_MAX, CNT_W'(1));
        send_item(make_query('0));
    endtask

    // full-depth search, and a count register beyond the table depth
    task automatic test_large_table();
        apply_settings(POS_MIN, POS_MAX, CNT_W'(1024));
        // put entries 0..3 back below the ramp so the walk goes deep
        for (int k = 0; k < 4; k++)
            send_item(make_write(10'(k), clamp_pos(-8388608 + 3 * k), $urandom()));
        send_item(make_query(map_pos[1000]));
        send_item(make_query(POS_MAX));
        apply_settings(POS_MIN, POS_MAX, '1);
        send_item(make_query(map_pos[1020]));
        send_item(make_query(POS_MAX));
    endtask

    // receiver holds off while the sender keeps offering, so the block backs up;
    // afterwards the sender waits for every answer before going on
    task automatic test_backpressure();
        longint lo_pos, hi_pos;
        gap_max = 0;
        apply_settings(POS_MIN, POS_MAX, CNT_W'(8));
        load_ramp(8, -40000, 10000, 1'b1, lo_pos, hi_pos);
        hold_request = HOLD_OFF_CYCLES;
        repeat (12)
            send_item(make_query(clamp_pos(lo_pos +
                longint'($urandom_range(0, 32'(hi_pos - lo_pos))))));
        drain_results();
        gap_max = 6;
    endtask

    // phases: pick registers, load a ramp, then mostly well-aimed queries
    // with some stray writes and wild positions mixed in
    task automatic test_random_traffic();
        int                      pick, count, queries, max_step, sent;
        longint                  start, lo_pos, hi_pos, span, margin, q;
        logic signed [POS_W-1:0] wlo, whi, rnd_pos;
        logic [CNT_W-1:0]        n_cfg;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                n_cfg = CNT_W'($urandom_range(0, 1));
            else if (pick == 1)
                n_cfg = CNT_W'($urandom_range(200, 1024));
            else if (pick == 2)
                n_cfg = CNT_W'($urandom_range(1025, 2047));
            else
                n_cfg = CNT_W'($urandom_range(2, 24));
            // large counts make slow queries, so those phases stay short
            count   = (n_cfg < 2) ? 4 : ((n_cfg > 24) ? 24 : int'(n_cfg));
            queries = (n_cfg > 24) ? 6 : 2 * count + 8;
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            case ($urandom_range(0, 3))
                0:       max_step = 1;
                1:       max_step = 16;
                2:       max_step = 1000;
                default: max_step = 100000;
            endcase
            if ($urandom_range(0, 3) == 0) begin
                rnd_pos = POS_W'($urandom());
                start   = rnd_pos;
            end else begin
                start = longint'($urandom_range(0, 200000)) - 100000;
            end
            load_ramp(count, start, max_step, 1'($urandom_range(0, 1)), lo_pos, hi_pos);
            sent  += count;
            span   = hi_pos - lo_pos;
            margin = span / 4 + 16;

            case ($urandom_range(0, 9))
                6, 7: begin
                    wlo = clamp_pos(lo_pos - longint'($urandom_range(0, 32'(margin)))
                                    + longint'($urandom_range(0, 32'(margin))));
                    whi = clamp_pos(hi_pos - longint'($urandom_range(0, 32'(margin)))
                                    + longint'($urandom_range(0, 32'(margin))));
                end
                8: begin
                    wlo = POS_W'($urandom());
                    whi = POS_W'($urandom());
                end
                9: begin
                    wlo = clamp_pos(hi_pos);
                    whi = clamp_pos(lo_pos);
                end
                default: begin
                    wlo = POS_MIN;
                    whi = POS_MAX;
                end
            endcase
            apply_settings(wlo, whi, n_cfg);

            for (int k = 0; k < queries; k++) begin
                if ($urandom_range(0, 7) == 0) begin
                    rnd_pos = POS_W'($urandom());
                    send_item(make_write(10'($urandom()), rnd_pos, $urandom()));
                end else begin
                    case ($urandom_range(0, 9))
                        7: q = map_pos[$urandom_range(0, count - 1)];
                        8: q = (($urandom_range(0, 1) == 0) ? longint'(win_lo) : longint'(win_hi))
                               + longint'($urandom_range(0, 2)) - 1;
                        9: begin
                            rnd_pos = POS_W'($urandom());
                            q = rnd_pos;
                        end
                        default: q = lo_pos - margin
                                     + longint'($urandom_range(0, 32'(span + 2 * margin)));
                    endcase
                    send_item(make_query(clamp_pos(q)));
                end
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // receiver: its own stall pattern, plus long hold-offs on request
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        rx_cycle++;
        if (rx_cycle % 300 == 0)
            stall_mode = t_rx_mode'($urandom_range(0, 3));
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            case (stall_mode)
                RX_ALWAYS:   out_ready <= 1'b1;
                RX_RANDOM:   out_ready <= ($urandom_range(0, 3) != 0);
                RX_PERIODIC: out_ready <= ((rx_cycle % 7) < 4);
                default:     out_ready <= ($urandom_range(0, 1) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // result check: every accepted result against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk) begin : check_results
        t_fli_out want;
        if (rst_n && out_valid && out_ready) begin
            if (field_expected.size() == 0) begin
                $error("result with no query waiting: field_z %0d status %0d",
                       out_item.field_z, out_item.status);
                fail_count++;
            end else begin
                want = field_expected.pop_front();
                if (out_item.field_z !== want.field_z) begin
                    $error("field_z mismatch: expected %0d, actual %0d",
                           want.field_z, out_item.field_z);
                    fail_count++;
                end
                if (out_item.status !== want.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, out_item.status);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: too long with no item moving on either side ends the run
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("field_map_linear_interpolator verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_table_load();
        test_field_extremes();
        test_special_cases();
        test_register_corners();
        test_large_table();
        test_backpressure();
        test_random_traffic();

        drain_results();
        // a late result with nothing queued would still be flagged here
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d table writes and %0d queries over %0d register settings",
                 n_writes, n_queries, n_settings);
        $display("queries seen: %0d interpolated, %0d outside window, %0d no segment, %0d %s",
                 status_count[ST_OK], status_count[ST_WINDOW], status_count[ST_NOSEG],
                 status_count[ST_ZERO], "zero-width");
        if (fail_count == 0 && field_expected.size() == 0)
            $display("field_map_linear_interpolator verification clean");
        else
            $display("field_map_linear_interpolator verification failed");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/fli_pkg.sv
rtl/core/fli_table.sv
rtl/core/fli_alu.sv
rtl/core/field_map_linear_interpolator.sv
rtl/core/fli_checker.sv
tb/tb_top.sv
